// ===== rtl/ssp_pkg.sv =====
// shared types and constants for the segmented stack with pop-at unit
// no dependencies
package ssp_pkg;

   localparam int OP_W       = 2;
   localparam int VALUE_W    = 32;
   localparam int SIDX_W     = 3;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH   = 2'd0,
      OP_POP    = 2'd1,
      OP_POP_AT = 2'd2,
      OP_QUERY  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SETTLE,
      ST_READ,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic settle;
      logic read;
   } cmd_type;

endpackage

// ===== rtl/ssp_ctrl.sv =====
// sequencer for the segmented stack: load, execute, settle, read, send
// depends on ssp_pkg
module ssp_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output ssp_pkg::cmd_type cmd
);
   import ssp_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_SETTLE;
         end
         ST_SETTLE: begin
            cmd.settle = 1'b1;
            state_in   = ST_READ;
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_SEND;
         end
         ST_SEND: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/ssp_dpath.sv =====
// datapath: substack counts, current pointer, word memory and result registers
// depends on ssp_pkg
module ssp_dpath #(
   parameter int NUM_STACKS  = 8,
   parameter int STACK_DEPTH = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ssp_pkg::cmd_type                   cmd,
   input  ssp_pkg::op_type                    op,
   input  logic signed [ssp_pkg::VALUE_W-1:0] value,
   input  logic [ssp_pkg::SIDX_W-1:0]         stack_index,
   output logic                               accepted,
   output logic signed [ssp_pkg::VALUE_W-1:0] top_value,
   output logic                               top_valid,
   output logic                               is_empty,
   output logic                               is_full
);
   import ssp_pkg::*;

   localparam int IDX_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int WORDS  = NUM_STACKS * STACK_DEPTH;
   localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_STACKS - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);

   op_type                     op_ff;
   logic signed [VALUE_W-1:0]  value_ff;
   logic [SIDX_W-1:0]          sidx_ff;
   logic [CNT_W-1:0]           counts_ff [NUM_STACKS];
   logic [CNT_W-1:0]           counts_in [NUM_STACKS];
   logic [IDX_W-1:0]           cur_ff;
   logic [IDX_W-1:0]           cur_in;
   logic                       drained_ff;
   logic                       drained_in;
   logic                       acc_ff;
   logic                       acc_in;
   logic signed [VALUE_W-1:0]  rd_ff;
   logic                       valid_ff;
   logic                       full_ff;
   logic signed [VALUE_W-1:0]  mem [WORDS];

   logic [IDX_W-1:0]  push_base;
   logic              base_full;
   logic [IDX_W-1:0]  push_cur;
   logic [CNT_W-1:0]  push_cnt;
   logic              push_ok;
   logic [ADDR_W-1:0] push_addr;
   logic              pop_ok;
   logic              pa_in_range;
   logic [IDX_W-1:0]  pa_idx;
   logic              pa_ok;
   logic              found;
   logic [IDX_W-1:0]  hi_idx;
   logic [ADDR_W-1:0] top_addr;
   logic              mem_we;

   // input item latch
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= op;
         value_ff <= value;
         sidx_ff  <= stack_index;
      end
   end

   // push target, pop and pop-at checks
   always_comb begin
      push_base   = drained_ff ? '0 : cur_ff;
      base_full   = (counts_ff[push_base] == FULL_CNT);
      push_cur    = (base_full && (push_base != LAST_IDX)) ? push_base + 1'b1 : push_base;
      push_cnt    = counts_ff[push_cur];
      push_ok     = (push_cnt != FULL_CNT);
      push_addr   = ADDR_W'(int'(push_cur) * STACK_DEPTH + int'(push_cnt));
      pop_ok      = !drained_ff && (counts_ff[cur_ff] != '0);
      pa_in_range = (32'(sidx_ff) < NUM_STACKS);
      pa_idx      = IDX_W'(sidx_ff);
      pa_ok       = pa_in_range && (counts_ff[pa_idx] != '0);
      mem_we      = cmd.exec && (op_ff == OP_PUSH) && push_ok;
   end

   // highest nonempty substack at or below the pointer
   always_comb begin
      found  = 1'b0;
      hi_idx = '0;
      for (int i = 0; i < NUM_STACKS; i++) begin
         if ((counts_ff[i] != '0) && (IDX_W'(i) <= cur_ff)) begin
            found  = 1'b1;
            hi_idx = IDX_W'(i);
         end
      end
   end

   always_comb begin
      counts_in  = counts_ff;
      cur_in     = cur_ff;
      drained_in = drained_ff;
      acc_in     = acc_ff;
      if (cmd.exec) begin
         acc_in = 1'b0;
         case (op_ff)
            OP_PUSH: begin
               drained_in = 1'b0;
               cur_in     = push_cur;
               acc_in     = push_ok;
               if (push_ok) begin
                  counts_in[push_cur] = push_cnt + 1'b1;
               end
            end
            OP_POP: begin
               acc_in = pop_ok;
               if (pop_ok) begin
                  counts_in[cur_ff] = counts_ff[cur_ff] - 1'b1;
               end
            end
            OP_POP_AT: begin
               acc_in = pa_ok;
               if (pa_ok) begin
                  counts_in[pa_idx] = counts_ff[pa_idx] - 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
      if (cmd.settle && !drained_ff) begin
         if (found) begin
            cur_in = hi_idx;
         end else begin
            cur_in     = '0;
            drained_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_STACKS; i++) begin
            counts_ff[i] <= '0;
         end
         cur_ff     <= '0;
         drained_ff <= 1'b0;
      end else begin
         counts_ff  <= counts_in;
         cur_ff     <= cur_in;
         drained_ff <= drained_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // word memory
   assign top_addr = ADDR_W'(int'(cur_ff) * STACK_DEPTH + int'(counts_ff[cur_ff]) - 1);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[push_addr] <= value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_ff <= mem[top_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         valid_ff <= !drained_ff;
         full_ff  <= !drained_ff && (cur_ff == LAST_IDX) && (counts_ff[cur_ff] == FULL_CNT);
      end
   end

   assign accepted  = acc_ff;
   assign top_value = valid_ff ? rd_ff : '0;
   assign top_valid = valid_ff;
   assign is_empty  = !valid_ff;
   assign is_full   = full_ff;

endmodule

// ===== rtl/segmented_stack_with_pop_at_unit.sv =====
// top level of the segmented stack with pop-at unit
// depends on ssp_pkg, ssp_ctrl and ssp_dpath
//
//   channel | ports                        | carries
//   req     | req_tvalid/tready/tdata[39:0] | op, value, stack_index
//   rsp     | rsp_tvalid/tready/tdata[39:0] | accepted, top_value, flags
//
// one item at a time: accept, execute, settle pointer, memory read, send
// the word memory read port and the settle step each have a state of their own
// synchronous reset clears all counts, the pointer and the drained flag
// req_tready stays low until the previous result has been taken
module segmented_stack_with_pop_at_unit #(
   parameter int NUM_STACKS  = 8,
   parameter int STACK_DEPTH = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // op[1:0], value[33:2], stack_index[36:34], zero pad
   input  logic [ssp_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // accepted[0], top_value[32:1], top_valid[33], is_empty[34], is_full[35], zero pad
   output logic [ssp_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import ssp_pkg::*;

   cmd_type                   cmd;
   op_type                    req_op;
   logic signed [VALUE_W-1:0] req_value;
   logic [SIDX_W-1:0]         req_sidx;
   logic                      rsp_accepted;
   logic signed [VALUE_W-1:0] rsp_top_value;
   logic                      rsp_top_valid;
   logic                      rsp_is_empty;
   logic                      rsp_is_full;

   assign req_op    = op_type'(req_tdata[OP_W-1:0]);
   assign req_value = req_tdata[OP_W+VALUE_W-1:OP_W];
   assign req_sidx  = req_tdata[OP_W+VALUE_W+SIDX_W-1:OP_W+VALUE_W];

   ssp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   ssp_dpath #(
      .NUM_STACKS  (NUM_STACKS),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .op          (req_op),
      .value       (req_value),
      .stack_index (req_sidx),
      .accepted    (rsp_accepted),
      .top_value   (rsp_top_value),
      .top_valid   (rsp_top_valid),
      .is_empty    (rsp_is_empty),
      .is_full     (rsp_is_full)
   );

   assign rsp_tdata = {4'd0, rsp_is_full, rsp_is_empty, rsp_top_valid,
                       rsp_top_value, rsp_accepted};

endmodule
